### design/assert_macros.svh
// Assertion helpers used by the datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

### design/dltq_pkg.sv
package dltq_pkg;

    // Queue geometry
    localparam int QUEUE_DEPTH = 16;
    localparam int MAX_EMIT    = 16;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int EMIT_W      = $clog2(MAX_EMIT + 1);

    // Field widths
    localparam int ID_W    = 8;
    localparam int ARG_W   = 16;
    localparam int DELAY_W = 15;

    // Operation codes
    localparam logic FUNC_TICK   = 1'b0;
    localparam logic FUNC_INSERT = 1'b1;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_EXPIRED   = 2'd0,
        KIND_INSERTED  = 2'd1,
        KIND_FULL      = 2'd2,
        KIND_IDLE_TICK = 2'd3
    } t_kind;

    typedef struct packed {
        logic               func;
        logic [ID_W-1:0]    callback_id;
        logic [ARG_W-1:0]   argument;
        logic [DELAY_W-1:0] delay_ticks;
        logic               masked;
    } t_item;

    typedef struct packed {
        t_kind            kind;
        logic [ID_W-1:0]  expired_id;
        logic [ARG_W-1:0] expired_argument;
        logic             last;
    } t_result;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_INS_WALK,
        S_TICK_SCAN,
        S_TICK_EMIT
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;
        logic walk_step;
        logic place;
        logic scan_step;
        logic scan_dec;
        logic emit;
        logic res_full;
        logic res_none;
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic func;
        logic masked;
        logic full;
        logic empty;
        logic walk_go;
        logic scan_go;
        logic head_exp;
        logic last_emit;
    } t_status;

endpackage

### design/dltq_ctrl.sv
module dltq_ctrl
    import dltq_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    busy
);

    t_state r_state;
    t_state n_state;

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_status.func == FUNC_INSERT) begin
                    n_state = i_status.full ? S_IDLE : S_INS_WALK;
                end else begin
                    n_state = i_status.empty ? S_IDLE : S_TICK_SCAN;
                end
            end
            S_INS_WALK: begin
                if (!i_status.walk_go) begin
                    n_state = S_IDLE;
                end
            end
            S_TICK_SCAN: begin
                if (!i_status.scan_go) begin
                    n_state = i_status.masked ? S_IDLE : S_TICK_EMIT;
                end
            end
            S_TICK_EMIT: begin
                if (!i_status.head_exp || i_status.last_emit) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Drive datapath commands
    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load = start;
            end
            S_DECODE: begin
                if (i_status.func == FUNC_INSERT) begin
                    o_cmd.res_full = i_status.full;
                end else begin
                    o_cmd.res_none = i_status.empty;
                end
            end
            S_INS_WALK: begin
                o_cmd.walk_step = i_status.walk_go;
                o_cmd.place     = !i_status.walk_go;
            end
            S_TICK_SCAN: begin
                o_cmd.scan_step = i_status.scan_go;
                o_cmd.scan_dec  = !i_status.scan_go;
                o_cmd.res_none  = !i_status.scan_go && i_status.masked;
            end
            S_TICK_EMIT: begin
                o_cmd.emit     = i_status.head_exp;
                o_cmd.res_none = !i_status.head_exp;
            end
            default: o_cmd = '0;
        endcase
    end

    assign busy = (r_state != S_IDLE);

endmodule

### design/dltq_dpath.sv
`include "assert_macros.svh"

module dltq_dpath
    import dltq_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_item   i_item,
    input  t_cmd    i_cmd,
    output t_status o_status,
    output logic    o_valid,
    output t_result o_result
);

    // Entry storage, ordered by expiry
    logic [DELAY_W-1:0] r_delta [QUEUE_DEPTH];
    logic [ID_W-1:0]    r_cb    [QUEUE_DEPTH];
    logic [ARG_W-1:0]   r_arg   [QUEUE_DEPTH];
    logic [CNT_W-1:0]   r_count;

    // Working registers for the current item
    t_item              r_item;
    logic [CNT_W-1:0]   r_idx;
    logic [DELAY_W-1:0] r_rem;
    logic [EMIT_W-1:0]  r_emitted;

    logic               r_valid;
    t_result            r_result;
    t_result            n_result;

    logic [DELAY_W-1:0] rd_delta;
    logic [DELAY_W-1:0] n_split;
    logic               idx_in;

    // Read the entry under the walk pointer
    assign idx_in   = (r_idx < r_count);
    assign rd_delta = r_delta[r_idx[IDX_W-1:0]];
    assign n_split  = rd_delta - r_rem;

    // Report status
    always_comb begin
        o_status.func      = r_item.func;
        o_status.masked    = r_item.masked;
        o_status.full      = (r_count == CNT_W'(QUEUE_DEPTH));
        o_status.empty     = (r_count == '0);
        o_status.walk_go   = idx_in && (rd_delta <= r_rem);
        o_status.scan_go   = idx_in && (rd_delta == '0);
        o_status.head_exp  = (r_count != '0) && (r_delta[0] == '0)
                             && (r_emitted < EMIT_W'(MAX_EMIT));
        o_status.last_emit = (r_count == CNT_W'(1)) || (r_delta[1] != '0)
                             || (r_emitted + EMIT_W'(1) == EMIT_W'(MAX_EMIT));
    end

    // Latch the item and advance the walk
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item    <= i_item;
            r_idx     <= '0;
            r_rem     <= i_item.delay_ticks;
            r_emitted <= '0;
        end else begin
            if (i_cmd.walk_step) begin
                r_rem <= r_rem - rd_delta;
                r_idx <= r_idx + CNT_W'(1);
            end
            if (i_cmd.scan_step) begin
                r_idx <= r_idx + CNT_W'(1);
            end
            if (i_cmd.emit) begin
                r_emitted <= r_emitted + EMIT_W'(1);
            end
        end
    end

    // Update entries: open a slot on insert, age on tick, drop the head on emit
    always_ff @(posedge i_clk) begin
        if (i_cmd.place) begin
            for (int j = 1; j < QUEUE_DEPTH; j++) begin
                if ((CNT_W'(j) > r_idx) && (CNT_W'(j) <= r_count)) begin
                    r_cb[j]    <= r_cb[j-1];
                    r_arg[j]   <= r_arg[j-1];
                    r_delta[j] <= (CNT_W'(j) == r_idx + CNT_W'(1)) ? n_split
                                                                    : r_delta[j-1];
                end
            end
            for (int j = 0; j < QUEUE_DEPTH; j++) begin
                if (CNT_W'(j) == r_idx) begin
                    r_delta[j] <= r_rem;
                    r_cb[j]    <= r_item.callback_id;
                    r_arg[j]   <= r_item.argument;
                end
            end
        end else if (i_cmd.scan_dec) begin
            if (idx_in) begin
                r_delta[r_idx[IDX_W-1:0]] <= rd_delta - DELAY_W'(1);
            end
        end else if (i_cmd.emit) begin
            for (int j = 0; j < QUEUE_DEPTH - 1; j++) begin
                r_delta[j] <= r_delta[j+1];
                r_cb[j]    <= r_cb[j+1];
                r_arg[j]   <= r_arg[j+1];
            end
        end
    end

    // Track occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.place) begin
            r_count <= r_count + CNT_W'(1);
        end else if (i_cmd.emit) begin
            r_count <= r_count - CNT_W'(1);
        end
    end

    // Register the result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.place | i_cmd.emit | i_cmd.res_full | i_cmd.res_none;
        end
    end

    // Form the result payload
    always_comb begin
        n_result      = '0;
        n_result.last = 1'b1;
        priority if (i_cmd.emit) begin
            n_result.kind             = KIND_EXPIRED;
            n_result.expired_id       = r_cb[0];
            n_result.expired_argument = r_arg[0];
            n_result.last             = o_status.last_emit;
        end else if (i_cmd.place) begin
            n_result.kind = KIND_INSERTED;
        end else if (i_cmd.res_full) begin
            n_result.kind = KIND_FULL;
        end else begin
            n_result.kind = KIND_IDLE_TICK;
        end
    end

    // Register the result payload
    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

    `ASSERT_NEVER(a_count_bound, i_clk, i_rst_n, r_count > CNT_W'(QUEUE_DEPTH), "entry count exceeds queue depth")
    `ASSERT_CLK(a_place_grows, i_clk, i_rst_n, i_cmd.place |=> (r_count == $past(r_count) + CNT_W'(1)), "insert did not add one entry")
    `ASSERT_CLK(a_single_last, i_clk, i_rst_n, (o_valid && (o_result.kind != KIND_EXPIRED)) |-> o_result.last, "single result not marked last")
    `ASSERT_NEVER(a_emit_empty, i_clk, i_rst_n, i_cmd.emit && (r_count == '0), "emit from an empty queue")

endmodule

### design/delta_list_timer_queue_unit.sv
// Delta-list timer queue: a sorted callout queue of QUEUE_DEPTH entries.
// Input channel: drive i_item and raise start; the item is taken at a clock
// edge where start is high and busy is low. Operation insert places a
// callout, operation tick ages the queue and dispatches expired callouts.
// Output channel: each result shows on o_result for one cycle with o_valid
// high. An insert or a masked tick gives one result; an unmasked tick gives
// one result per expired entry (at most MAX_EMIT, or a single idle result
// if none expired), the final one marked by last. The sequence is a decode
// step, then the list walk visits one entry per cycle. An insert walks past
// the entries whose delta fits its delay, then places the callout. A tick
// skips the zero-delta entries at the head, decrements the first nonzero
// delta and, if unmasked, then dispatches one expired callout per cycle. An
// insert into a full queue or a tick on an empty one answers from the decode
// step. busy falls as the final result goes out, so the next item can be
// taken in the cycle that result is shown.
// Reset (synchronous, active low) empties the queue; entry storage is not
// cleared. The receiver cannot stall: every result must be taken as shown.
module delta_list_timer_queue_unit
    import dltq_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    input  t_item   i_item,
    output logic    busy,
    output logic    o_valid,
    output t_result o_result
);

    t_cmd    cmd;
    t_status status;

    // Sequence the walk and dispatch
    dltq_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_status (status),
        .o_cmd    (cmd),
        .busy     (busy)
    );

    // Hold the entries and form results
    dltq_dpath u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (cmd),
        .o_status (status),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

endmodule
